>>> hw/rtl/bllca_pkg.sv
// Package: constants, codes, types and helper functions of the binary lifting LCA core.
`default_nettype none
package bllca_pkg;

   localparam int MAX_NODES = 131072;
   localparam int LEVELS    = 17;
   localparam int NODE_W    = 17;
   localparam int LVL_W     = $clog2(LEVELS);
   localparam int JDEPTH    = MAX_NODES * LEVELS;
   localparam int JADDR_W   = $clog2(JDEPTH);
   localparam int DADDR_W   = $clog2(MAX_NODES);

   localparam int REQ_W     = 72;
   localparam int RSP_W     = 24;
   localparam int FIRST_LO  = 0;
   localparam int PARENT_LO = FIRST_LO + NODE_W;
   localparam int DEPTH_LO  = PARENT_LO + NODE_W;
   localparam int SECOND_LO = DEPTH_LO + NODE_W;

   localparam logic [LVL_W-1:0]  TOP_LVL     = LVL_W'(LEVELS - 1);
   localparam logic [NODE_W-1:0] LAST_MAX    = NODE_W'(MAX_NODES - 1);
   localparam logic [NODE_W:0]   MAX_NODES_X = (NODE_W + 1)'(MAX_NODES);

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLD_RD0,
      ST_BLD_RD1,
      ST_BLD_WR,
      ST_Q_DEP,
      ST_Q_SWAP,
      ST_LIFT_CHK,
      ST_LIFT_JMP,
      ST_LIFT_DEP,
      ST_LIFT_END,
      ST_UP_RD,
      ST_UP_CMP,
      ST_FIN_RD,
      ST_FIN_DAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                wen;
      logic [JADDR_W-1:0]  waddr;
      logic [NODE_W-1:0]   wdata;
      logic [JADDR_W-1:0]  raddr0;
      logic [JADDR_W-1:0]  raddr1;
   } jmem_req_type;

   typedef struct packed {
      logic                wen;
      logic [DADDR_W-1:0]  waddr;
      logic [NODE_W-1:0]   wdata;
      logic [DADDR_W-1:0]  raddr0;
      logic [DADDR_W-1:0]  raddr1;
   } dmem_req_type;

   function automatic logic [JADDR_W-1:0] jidx(input logic [NODE_W-1:0] node,
                                                input logic [LVL_W-1:0] lvl);
      return JADDR_W'(node) * JADDR_W'(LEVELS) + JADDR_W'(lvl);
   endfunction

   function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] node);
      return ({1'b0, node} < MAX_NODES_X) ? node : '0;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/binary_lifting_lca_core.sv
// Top level of the binary lifting LCA core: sequencer, jump memory and depth memory.
//
//   channel  | direction | tdata / data                      | tuser
//   req_     | in        | first, parent, depth, second node | func
//   rsp_     | out       | ancestor node                     | -
//   csr_     | in        | node_count                        | -
//
// Load, nop: done in idle. Build: BLD_RD0, BLD_RD1 and BLD_WR per node and level;
// each entry is two dependent reads of the jump memory and one write.
// Query: two lifting passes of 17 levels over the registered memory reads.
// No clearing pass at reset; node 0 reads as zero by a tag on each read.
// A result waits in the rsp register; a new word is taken meanwhile, a query holds in its
// last step while the register is full.
`default_nettype none
module binary_lifting_lca_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [16:0] first_node, [33:17] parent_node, [50:34] node_depth, [67:51] second_node
   input  wire logic [bllca_pkg::REQ_W-1:0]   req_tdata,
   // [1:0] func
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [16:0] ancestor_node
   output logic      [bllca_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bllca_pkg::NODE_W-1:0]  csr_wdata
);

   bllca_pkg::jmem_req_type      jmem_req;
   bllca_pkg::dmem_req_type      dmem_req;
   logic [bllca_pkg::NODE_W-1:0] jmem_q0, jmem_q1, dmem_q0, dmem_q1;

   bllca_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .jmem_req   (jmem_req),
      .jmem_q0    (jmem_q0),
      .jmem_q1    (jmem_q1),
      .dmem_req   (dmem_req),
      .dmem_q0    (dmem_q0),
      .dmem_q1    (dmem_q1)
   );

   bllca_ram #(
      .DEPTH  (bllca_pkg::JDEPTH),
      .DATA_W (bllca_pkg::NODE_W)
   ) u_jump_mem (
      .clock  (clock),
      .wen    (jmem_req.wen),
      .waddr  (jmem_req.waddr),
      .wdata  (jmem_req.wdata),
      .raddr0 (jmem_req.raddr0),
      .raddr1 (jmem_req.raddr1),
      .rdata0 (jmem_q0),
      .rdata1 (jmem_q1)
   );

   bllca_ram #(
      .DEPTH  (bllca_pkg::MAX_NODES),
      .DATA_W (bllca_pkg::NODE_W)
   ) u_depth_mem (
      .clock  (clock),
      .wen    (dmem_req.wen),
      .waddr  (dmem_req.waddr),
      .wdata  (dmem_req.wdata),
      .raddr0 (dmem_req.raddr0),
      .raddr1 (dmem_req.raddr1),
      .rdata0 (dmem_q0),
      .rdata1 (dmem_q1)
   );

endmodule
`default_nettype wire

>>> hw/rtl/bllca_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none
module bllca_ram #(
   parameter int DEPTH  = 2,
   parameter int DATA_W = 1,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wen,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr0,
   input  wire logic [ADDR_W-1:0] raddr1,
   output logic      [DATA_W-1:0] rdata0,
   output logic      [DATA_W-1:0] rdata1
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule
`default_nettype wire

>>> hw/rtl/bllca_engine.sv
// Sequencer: load, jump table build and LCA query over the jump and depth memories.
`default_nettype none
module bllca_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [bllca_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [bllca_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bllca_pkg::NODE_W-1:0]  csr_wdata,
   output bllca_pkg::jmem_req_type            jmem_req,
   input  wire logic [bllca_pkg::NODE_W-1:0]  jmem_q0,
   input  wire logic [bllca_pkg::NODE_W-1:0]  jmem_q1,
   output bllca_pkg::dmem_req_type            dmem_req,
   input  wire logic [bllca_pkg::NODE_W-1:0]  dmem_q0,
   input  wire logic [bllca_pkg::NODE_W-1:0]  dmem_q1
);

   bllca_pkg::state_type state_ff, state_in;

   logic [bllca_pkg::NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [bllca_pkg::NODE_W-1:0] da_ff, da_in, db_ff, db_in;
   logic [bllca_pkg::NODE_W-1:0] i_ff, i_in, last_ff, last_in;
   logic [bllca_pkg::NODE_W-1:0] res_ff, res_in;
   logic [bllca_pkg::NODE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bllca_pkg::NODE_W-1:0] node_count_ff, node_count_in;
   logic [bllca_pkg::LVL_W-1:0]  lv_ff, lv_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         jz0_ff, jz0_in, jz1_ff, jz1_in;
   logic                         dz0_ff, dz0_in, dz1_ff, dz1_in;

   logic [bllca_pkg::NODE_W-1:0] jn0, jn1, dn0, dn1;
   logic [bllca_pkg::LVL_W-1:0]  jl;
   logic [bllca_pkg::NODE_W-1:0] jq0, jq1, dq0, dq1;
   logic [bllca_pkg::NODE_W-1:0] f_first, f_parent, f_depth, f_second, last_cnt;
   logic [bllca_pkg::NODE_W:0]   lift_step, lift_sum;
   bllca_pkg::func_type          func;
   logic                         accept, lift_go, rsp_free;

   // node 0 is the sentinel: every read of it returns zero
   assign jq0 = jz0_ff ? '0 : jmem_q0;
   assign jq1 = jz1_ff ? '0 : jmem_q1;
   assign dq0 = dz0_ff ? '0 : dmem_q0;
   assign dq1 = dz1_ff ? '0 : dmem_q1;

   assign func     = bllca_pkg::func_type'(req_tuser);
   assign f_first  = req_tdata[bllca_pkg::FIRST_LO  +: bllca_pkg::NODE_W];
   assign f_parent = req_tdata[bllca_pkg::PARENT_LO +: bllca_pkg::NODE_W];
   assign f_depth  = req_tdata[bllca_pkg::DEPTH_LO  +: bllca_pkg::NODE_W];
   assign f_second = req_tdata[bllca_pkg::SECOND_LO +: bllca_pkg::NODE_W];

   assign req_tready = (state_ff == bllca_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign last_cnt   = (node_count_ff > bllca_pkg::LAST_MAX) ? bllca_pkg::LAST_MAX
                                                             : node_count_ff;
   assign lift_step  = (bllca_pkg::NODE_W + 1)'(1) << lv_ff;
   assign lift_sum   = {1'b0, da_ff} + lift_step;
   assign lift_go    = ({1'b0, db_ff} >= lift_sum);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bllca_pkg::RSP_W - bllca_pkg::NODE_W){1'b0}}, rsp_data_ff};
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bllca_pkg::ST_IDLE: begin
            if (accept) begin
               case (func)
                  bllca_pkg::FUNC_BUILD:
                     state_in = (last_cnt == '0) ? bllca_pkg::ST_IDLE : bllca_pkg::ST_BLD_RD0;
                  bllca_pkg::FUNC_QUERY: state_in = bllca_pkg::ST_Q_DEP;
                  default:               state_in = bllca_pkg::ST_IDLE;
               endcase
            end
         end
         bllca_pkg::ST_BLD_RD0: state_in = bllca_pkg::ST_BLD_RD1;
         bllca_pkg::ST_BLD_RD1: state_in = bllca_pkg::ST_BLD_WR;
         bllca_pkg::ST_BLD_WR: begin
            if (i_ff == last_ff && lv_ff == bllca_pkg::TOP_LVL) begin
               state_in = bllca_pkg::ST_IDLE;
            end else begin
               state_in = bllca_pkg::ST_BLD_RD0;
            end
         end
         bllca_pkg::ST_Q_DEP:  state_in = bllca_pkg::ST_Q_SWAP;
         bllca_pkg::ST_Q_SWAP: state_in = bllca_pkg::ST_LIFT_CHK;
         bllca_pkg::ST_LIFT_CHK: begin
            if (lift_go) begin
               state_in = bllca_pkg::ST_LIFT_JMP;
            end else if (lv_ff == '0) begin
               state_in = bllca_pkg::ST_LIFT_END;
            end
         end
         bllca_pkg::ST_LIFT_JMP: state_in = bllca_pkg::ST_LIFT_DEP;
         bllca_pkg::ST_LIFT_DEP: begin
            state_in = (lv_ff == '0) ? bllca_pkg::ST_LIFT_END : bllca_pkg::ST_LIFT_CHK;
         end
         bllca_pkg::ST_LIFT_END: begin
            state_in = (a_ff == b_ff) ? bllca_pkg::ST_DONE : bllca_pkg::ST_UP_RD;
         end
         bllca_pkg::ST_UP_RD: state_in = bllca_pkg::ST_UP_CMP;
         bllca_pkg::ST_UP_CMP: begin
            state_in = (lv_ff == '0) ? bllca_pkg::ST_FIN_RD : bllca_pkg::ST_UP_RD;
         end
         bllca_pkg::ST_FIN_RD:  state_in = bllca_pkg::ST_FIN_DAT;
         bllca_pkg::ST_FIN_DAT: state_in = bllca_pkg::ST_DONE;
         bllca_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = bllca_pkg::ST_IDLE;
            end
         end
         default: state_in = bllca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      a_in          = a_ff;
      b_in          = b_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      i_in          = i_ff;
      last_in       = last_ff;
      lv_in         = lv_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      node_count_in = (csr_valid && csr_ready) ? csr_wdata : node_count_ff;
      jn0           = '0;
      jn1           = '0;
      jl            = '0;
      dn0           = '0;
      dn1           = '0;
      jmem_req.wen   = 1'b0;
      jmem_req.waddr = '0;
      jmem_req.wdata = '0;
      dmem_req.wen   = 1'b0;
      dmem_req.waddr = '0;
      dmem_req.wdata = '0;

      unique case (state_ff)
         bllca_pkg::ST_IDLE: begin
            if (accept) begin
               case (func)
                  bllca_pkg::FUNC_LOAD: begin
                     if (f_first != '0 && {1'b0, f_first} < bllca_pkg::MAX_NODES_X) begin
                        jmem_req.wen   = 1'b1;
                        jmem_req.waddr = bllca_pkg::jidx(f_first, '0);
                        jmem_req.wdata = bllca_pkg::clamp_node(f_parent);
                        dmem_req.wen   = 1'b1;
                        dmem_req.waddr = bllca_pkg::DADDR_W'(f_first);
                        dmem_req.wdata = f_depth;
                     end
                  end
                  bllca_pkg::FUNC_BUILD: begin
                     last_in = last_cnt;
                     i_in    = bllca_pkg::NODE_W'(1);
                     lv_in   = bllca_pkg::LVL_W'(1);
                  end
                  bllca_pkg::FUNC_QUERY: begin
                     a_in = bllca_pkg::clamp_node(f_first);
                     b_in = bllca_pkg::clamp_node(f_second);
                  end
                  default: ;
               endcase
            end
         end
         bllca_pkg::ST_BLD_RD0: begin
            jn0 = i_ff;
            jl  = lv_ff - bllca_pkg::LVL_W'(1);
         end
         bllca_pkg::ST_BLD_RD1: begin
            jn0 = jq0;
            jl  = lv_ff - bllca_pkg::LVL_W'(1);
         end
         bllca_pkg::ST_BLD_WR: begin
            jmem_req.wen   = 1'b1;
            jmem_req.waddr = bllca_pkg::jidx(i_ff, lv_ff);
            jmem_req.wdata = jq0;
            if (i_ff == last_ff) begin
               i_in  = bllca_pkg::NODE_W'(1);
               lv_in = lv_ff + bllca_pkg::LVL_W'(1);
            end else begin
               i_in = i_ff + bllca_pkg::NODE_W'(1);
            end
         end
         bllca_pkg::ST_Q_DEP: begin
            dn0 = a_ff;
            dn1 = b_ff;
         end
         bllca_pkg::ST_Q_SWAP: begin
            lv_in = bllca_pkg::TOP_LVL;
            if (dq0 > dq1) begin
               a_in  = b_ff;
               b_in  = a_ff;
               da_in = dq1;
               db_in = dq0;
            end else begin
               da_in = dq0;
               db_in = dq1;
            end
         end
         bllca_pkg::ST_LIFT_CHK: begin
            if (lift_go) begin
               jn0 = b_ff;
               jl  = lv_ff;
            end else if (lv_ff != '0) begin
               lv_in = lv_ff - bllca_pkg::LVL_W'(1);
            end
         end
         bllca_pkg::ST_LIFT_JMP: begin
            b_in = jq0;
            dn1  = jq0;
         end
         bllca_pkg::ST_LIFT_DEP: begin
            db_in = dq1;
            if (lv_ff != '0) begin
               lv_in = lv_ff - bllca_pkg::LVL_W'(1);
            end
         end
         bllca_pkg::ST_LIFT_END: begin
            if (a_ff == b_ff) begin
               res_in = a_ff;
            end else begin
               lv_in = bllca_pkg::TOP_LVL;
            end
         end
         bllca_pkg::ST_UP_RD: begin
            jn0 = a_ff;
            jn1 = b_ff;
            jl  = lv_ff;
         end
         bllca_pkg::ST_UP_CMP: begin
            if (jq0 != jq1) begin
               a_in = jq0;
               b_in = jq1;
            end
            if (lv_ff != '0) begin
               lv_in = lv_ff - bllca_pkg::LVL_W'(1);
            end
         end
         bllca_pkg::ST_FIN_RD: begin
            jn0 = a_ff;
         end
         bllca_pkg::ST_FIN_DAT: begin
            res_in = jq0;
         end
         bllca_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase

      jmem_req.raddr0 = bllca_pkg::jidx(jn0, jl);
      jmem_req.raddr1 = bllca_pkg::jidx(jn1, jl);
      dmem_req.raddr0 = bllca_pkg::DADDR_W'(dn0);
      dmem_req.raddr1 = bllca_pkg::DADDR_W'(dn1);
      jz0_in = (jn0 == '0);
      jz1_in = (jn1 == '0);
      dz0_in = (dn0 == '0);
      dz1_in = (dn1 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bllca_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= bllca_pkg::NODE_W'(1);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      i_ff        <= i_in;
      last_ff     <= last_in;
      lv_ff       <= lv_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      jz0_ff      <= jz0_in;
      jz1_ff      <= jz1_in;
      dz0_ff      <= dz0_in;
      dz1_ff      <= dz1_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/bllca_checker.sv
// Port-level checker of the binary lifting LCA core and its bind.
`default_nettype none
module bllca_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic [1:0]                  req_tuser,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [bllca_pkg::RSP_W-1:0] rsp_tdata
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // load, build and nop make no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != bllca_pkg::FUNC_QUERY && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result without query");

   // a query keeps the input side busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == bllca_pkg::FUNC_QUERY |=> !req_tready)
      else $error("word taken during query");

endmodule

bind binary_lifting_lca_core bllca_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
